// ===== hdl/tig_pkg.sv =====
`timescale 1ns / 1ps

package tig_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam int THICK_W   = 16;
  localparam int KEEP_W    = 17;
  localparam logic [THICK_W-1:0] THICK_MAX = 16'd64880;
  localparam logic [KEEP_W-1:0]  ONE_Q16   = 17'h10000;
  localparam int INSET_SHIFT = 16;
  localparam int INSET_HALF  = 98304;

  localparam int EDGE_LIM  = 20;
  localparam int EDGE_W    = EDGE_LIM + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int CROSS_W   = PROD_W;
  localparam int CROSS_LIM = 31;
  localparam int MAG_W     = CROSS_LIM;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int ROOT_STEPS = 32;

  localparam int NORM_W    = 16;
  localparam int NORM_FRAC = 14;
  localparam int NORM_ONE  = 16384;
  localparam int QUOT_BITS = 15;
  localparam int REM_W     = MAG_W + NORM_FRAC + 1;

  typedef struct packed {
    logic en;
    logic vld;
  } tig_ctl_t;

endpackage

// ===== hdl/tig_inset_lane.sv =====
`timescale 1ns / 1ps

module tig_inset_lane #(
  parameter int COORD_BITS = tig_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [COORD_BITS-1:0]          v,
  input  logic signed [COORD_BITS+1:0]          s,
  input  logic        [tig_pkg::KEEP_W-1:0]     keep,
  output logic signed [COORD_BITS-1:0]          inner
);

  localparam int C   = COORD_BITS;
  localparam int SW  = C + 2;
  localparam int DW  = C + 3;
  localparam int PW  = C + 20;
  localparam int NW  = C + 21;
  localparam int YW  = NW + 1 - tig_pkg::INSET_SHIFT;
  localparam int K   = YW + 2;
  localparam int MW  = YW + 1;
  localparam int QW  = YW - 1;
  localparam logic [MW-1:0] RECIP = MW'(((65'd1 << K) + 65'd2) / 65'd3);
  localparam logic signed [YW-1:0] HI = {{(YW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [YW-1:0] LO = {{(YW-C+1){1'b1}}, {(C-1){1'b0}}};

  logic signed [DW-1:0]   dv_r;
  logic signed [SW-1:0]   sa_r, sb_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [DW+tig_pkg::KEEP_W:0] prod_full;
  logic signed [NW-1:0]   num;
  logic        [NW-1:0]   amag;
  logic        [NW:0]     rnd;
  logic        [YW-1:0]   y_r;
  logic                   neg_c_r, neg_d_r;
  logic        [YW+MW-1:0] qp;
  logic        [QW-1:0]   qd_r;
  logic signed [YW-1:0]   sv;
  logic signed [C-1:0]    inner_r;

  assign prod_full = dv_r * $signed({1'b0, keep});
  assign num  = (NW'(sb_r) <<< tig_pkg::INSET_SHIFT) + NW'(prod_r);
  assign amag = num[NW-1] ? NW'(-num) : NW'(num);
  assign rnd  = (NW+1)'(amag) + (NW+1)'(tig_pkg::INSET_HALF);
  assign qp   = y_r * RECIP;
  assign sv   = neg_d_r ? -$signed(YW'(qd_r)) : $signed(YW'(qd_r));

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r    <= (DW'(v) <<< 1) + DW'(v) - DW'(s);
      sa_r    <= s;
      prod_r  <= prod_full[PW-1:0];
      sb_r    <= sa_r;
      y_r     <= rnd[NW:tig_pkg::INSET_SHIFT];
      neg_c_r <= num[NW-1];
      qd_r    <= qp[YW+MW-1:K];
      neg_d_r <= neg_c_r;
      if (sv > HI) begin
        inner_r <= HI[C-1:0];
      end else if (sv < LO) begin
        inner_r <= LO[C-1:0];
      end else begin
        inner_r <= sv[C-1:0];
      end
    end
  end

  assign inner = inner_r;

endmodule

// ===== hdl/tig_isqrt.sv =====
`timescale 1ns / 1ps

module tig_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tig_pkg::tig_ctl_t              ctl,
  input  logic [tig_pkg::SUM_W-1:0]      x,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           vld_o,
  output logic [tig_pkg::ROOT_W-1:0]     root,
  output logic [SIDE_W-1:0]              side_o
);

  localparam int N  = tig_pkg::ROOT_STEPS;
  localparam int XW = tig_pkg::SUM_W;

  logic [XW-1:0]     x_r [N];
  logic [XW-1:0]     r_r [N];
  logic [SIDE_W-1:0] s_r [N];
  logic [N-1:0]      v_r;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [XW-1:0] BIT = XW'(1) << (2 * (N - 1 - k));
    logic [XW-1:0]     xin, rin, trial, x_nxt, r_nxt;
    logic [SIDE_W-1:0] sin;
    logic              vin;

    if (k == 0) begin : g_first
      assign xin = x;
      assign rin = '0;
      assign sin = side_i;
      assign vin = ctl.vld;
    end else begin : g_next
      assign xin = x_r[k-1];
      assign rin = r_r[k-1];
      assign sin = s_r[k-1];
      assign vin = v_r[k-1];
    end

    always_comb begin
      trial = rin + BIT;
      if (xin >= trial) begin
        x_nxt = xin - trial;
        r_nxt = (rin >> 1) + BIT;
      end else begin
        x_nxt = xin;
        r_nxt = rin >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ctl.en) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        x_r[k] <= x_nxt;
        r_r[k] <= r_nxt;
        s_r[k] <= sin;
      end
    end
  end

  assign vld_o  = v_r[N-1];
  assign root   = r_r[N-1][tig_pkg::ROOT_W-1:0];
  assign side_o = s_r[N-1];

endmodule

// ===== hdl/tig_div_lane.sv =====
`timescale 1ns / 1ps

module tig_div_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tig_pkg::MAG_W-1:0]         mag,
  input  logic [tig_pkg::ROOT_W-1:0]        len,
  output logic [tig_pkg::QUOT_BITS-1:0]     quot
);

  localparam int QB = tig_pkg::QUOT_BITS;
  localparam int RW = tig_pkg::REM_W;
  localparam int LW = tig_pkg::ROOT_W;

  logic [RW-1:0] rem_r [QB+1];
  logic [LW-1:0] d_r   [QB+1];
  logic [QB-1:0] q_r   [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'({mag, {tig_pkg::NORM_FRAC{1'b0}}}) + RW'(len >> 1);
      d_r[0]   <= (len == '0) ? LW'(1) : len;
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_bit
    localparam int J = QB - i;
    logic [RW-1:0] trial;
    assign trial = RW'(d_r[i-1]) << J;

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i] <= d_r[i-1];
        if (rem_r[i-1] >= trial) begin
          rem_r[i] <= rem_r[i-1] - trial;
          q_r[i]   <= q_r[i-1] | (QB'(1) << J);
        end else begin
          rem_r[i] <= rem_r[i-1];
          q_r[i]   <= q_r[i-1];
        end
      end
    end
  end

  assign quot = q_r[QB];

endmodule

// ===== hdl/triangle_inset_geometry.sv =====
`timescale 1ns / 1ps

// triangle inset and face normal, one triangle per transfer
// input channel: in_valid / in_stall with nine signed vertex coordinates
// result channel: out_valid / out_stall with nine inset coordinates and a
// signed Q1.14 unit normal; configuration: cfg_valid / cfg_ready / cfg_data
// writes the thickness, stored saturated at 0.99, ready is always high
// write thickness only while no triangle is in flight
// out_valid rises once the triangle has passed the input stage, the edge,
// cross and norm stages, the 32-step square root and 15-bit divider lanes
// throughput: one triangle per cycle without stall; every stage is pipelined
// nine inset lanes and three divider lanes run side by side
// reset (rst_n low, synchronous) empties the pipeline and clears thickness
// a stalled result is held in the output register, the next one moves into
// a skid register; only when the skid is full does in_stall rise and the
// whole pipeline hold
module triangle_inset_geometry #(
  parameter int COORD_BITS = tig_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_BITS-1:0]   in_a_x,
  input  logic signed [COORD_BITS-1:0]   in_a_y,
  input  logic signed [COORD_BITS-1:0]   in_a_z,
  input  logic signed [COORD_BITS-1:0]   in_b_x,
  input  logic signed [COORD_BITS-1:0]   in_b_y,
  input  logic signed [COORD_BITS-1:0]   in_b_z,
  input  logic signed [COORD_BITS-1:0]   in_c_x,
  input  logic signed [COORD_BITS-1:0]   in_c_y,
  input  logic signed [COORD_BITS-1:0]   in_c_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [COORD_BITS-1:0]   out_inner_a_x,
  output logic signed [COORD_BITS-1:0]   out_inner_a_y,
  output logic signed [COORD_BITS-1:0]   out_inner_a_z,
  output logic signed [COORD_BITS-1:0]   out_inner_b_x,
  output logic signed [COORD_BITS-1:0]   out_inner_b_y,
  output logic signed [COORD_BITS-1:0]   out_inner_b_z,
  output logic signed [COORD_BITS-1:0]   out_inner_c_x,
  output logic signed [COORD_BITS-1:0]   out_inner_c_y,
  output logic signed [COORD_BITS-1:0]   out_inner_c_z,
  output logic signed [tig_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [tig_pkg::NORM_W-1:0] out_normal_y,
  output logic signed [tig_pkg::NORM_W-1:0] out_normal_z,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tig_pkg::THICK_W-1:0]    cfg_data
);

  localparam int C       = COORD_BITS;
  localparam int EW      = C + 1;
  localparam int EDGE_W  = tig_pkg::EDGE_W;
  localparam int EDGE_LIM = tig_pkg::EDGE_LIM;
  localparam int SHE_W   = $clog2(EW + 1);
  localparam int EXW     = ((EW > EDGE_W) ? EW : EDGE_W) + 1;
  localparam int CROSS_W = tig_pkg::CROSS_W;
  localparam int CROSS_LIM = tig_pkg::CROSS_LIM;
  localparam int CSH_W   = $clog2(CROSS_W - CROSS_LIM + 1);
  localparam int MAG_W   = tig_pkg::MAG_W;
  localparam int NW      = tig_pkg::NORM_W;
  localparam int QB      = tig_pkg::QUOT_BITS;
  localparam int IN_W    = 9 * C;
  localparam int DSIDE_W = IN_W + 4;
  localparam int SIDE_W  = DSIDE_W + 3 * MAG_W;
  localparam int DLY     = QB + 1;
  localparam logic [QB-1:0] QONE = QB'(tig_pkg::NORM_ONE);

  logic en;
  logic [tig_pkg::THICK_W-1:0] thick_r;
  logic [tig_pkg::KEEP_W-1:0]  keep;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thick_r <= (cfg_data > tig_pkg::THICK_MAX) ? tig_pkg::THICK_MAX : cfg_data;
    end
  end

  assign keep = tig_pkg::ONE_Q16 - tig_pkg::KEEP_W'(thick_r);

  // input stage
  logic              v1_r;
  logic signed [C-1:0] p1_r [9];
  logic signed [C+1:0] sum_c [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= in_a_x;
      p1_r[1] <= in_a_y;
      p1_r[2] <= in_a_z;
      p1_r[3] <= in_b_x;
      p1_r[4] <= in_b_y;
      p1_r[5] <= in_b_z;
      p1_r[6] <= in_c_x;
      p1_r[7] <= in_c_y;
      p1_r[8] <= in_c_z;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sum
    assign sum_c[k] = (C+2)'(p1_r[k]) + (C+2)'(p1_r[3+k]) + (C+2)'(p1_r[6+k]);
  end

  // inset lanes
  logic signed [C-1:0] inner6 [9];

  for (genvar n = 0; n < 9; n++) begin : g_inset
    tig_inset_lane #(
      .COORD_BITS(C)
    ) u_inset (
      .clk  (clk),
      .en   (en),
      .v    (p1_r[n]),
      .s    (sum_c[n % 3]),
      .keep (keep),
      .inner(inner6[n])
    );
  end

  // normal: edges
  logic              v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic signed [EW-1:0]     e2_r [6];
  logic        [EW-1:0]     emag [6];
  logic        [EW-1:0]     emax;
  logic        [SHE_W-1:0]  esh;
  logic        [EXW-1:0]    eshr [6];
  logic signed [EDGE_W-1:0] e3_nxt [6];
  logic signed [EDGE_W-1:0] e3_r [6];
  logic signed [tig_pkg::PROD_W-1:0] pr4_r [6];
  logic signed [CROSS_W-1:0] cr_nxt [3];
  logic signed [CROSS_W-1:0] cr5_r [3];
  logic                      deg5_r, deg6_r, deg7_r, deg8_r;
  logic        [CROSS_W-1:0] cmag [3];
  logic        [CROSS_W-1:0] cmax;
  logic        [CSH_W-1:0]   csh;
  logic        [MAG_W-1:0]   m6_nxt [3];
  logic        [MAG_W-1:0]   m6_r [3], m7_r [3], m8_r [3];
  logic        [2:0]         n6_r, n7_r, n8_r;
  logic        [tig_pkg::SQ_W-1:0]  sq7_r [3];
  logic        [tig_pkg::SUM_W-1:0] sum8_r;
  logic signed [C-1:0]       inner7_r [9], inner8_r [9];

  always_comb begin
    emax = '0;
    esh  = '0;
    for (int i = 0; i < 6; i++) begin
      emag[i] = e2_r[i][EW-1] ? EW'(-e2_r[i]) : EW'(e2_r[i]);
      if (emag[i] > emax) begin
        emax = emag[i];
      end
    end
    for (int b = EDGE_LIM; b < EW; b++) begin
      if (emax[b]) begin
        esh = SHE_W'(b - EDGE_LIM + 1);
      end
    end
    for (int i = 0; i < 6; i++) begin
      eshr[i]   = EXW'(emag[i]) >> esh;
      e3_nxt[i] = e2_r[i][EW-1] ? -$signed(EDGE_W'(eshr[i])) : $signed(EDGE_W'(eshr[i]));
    end
  end

  always_comb begin
    cr_nxt[0] = pr4_r[0] - pr4_r[1];
    cr_nxt[1] = pr4_r[2] - pr4_r[3];
    cr_nxt[2] = pr4_r[4] - pr4_r[5];
  end

  always_comb begin
    cmax = '0;
    csh  = '0;
    for (int i = 0; i < 3; i++) begin
      cmag[i] = cr5_r[i][CROSS_W-1] ? CROSS_W'(-cr5_r[i]) : CROSS_W'(cr5_r[i]);
      if (cmag[i] > cmax) begin
        cmax = cmag[i];
      end
    end
    for (int b = CROSS_LIM; b < CROSS_W; b++) begin
      if (cmax[b]) begin
        csh = CSH_W'(b - CROSS_LIM + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      m6_nxt[i] = MAG_W'(cmag[i] >> csh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e2_r[k]   <= EW'(p1_r[3+k]) - EW'(p1_r[k]);
        e2_r[3+k] <= EW'(p1_r[6+k]) - EW'(p1_r[k]);
      end
      e3_r     <= e3_nxt;
      pr4_r[0] <= e3_r[1] * e3_r[5];
      pr4_r[1] <= e3_r[2] * e3_r[4];
      pr4_r[2] <= e3_r[2] * e3_r[3];
      pr4_r[3] <= e3_r[0] * e3_r[5];
      pr4_r[4] <= e3_r[0] * e3_r[4];
      pr4_r[5] <= e3_r[1] * e3_r[3];
      cr5_r    <= cr_nxt;
      deg5_r   <= (cr_nxt[0] == '0) && (cr_nxt[1] == '0) && (cr_nxt[2] == '0);
      m6_r     <= m6_nxt;
      n6_r     <= {cr5_r[2][CROSS_W-1], cr5_r[1][CROSS_W-1], cr5_r[0][CROSS_W-1]};
      deg6_r   <= deg5_r;
      for (int i = 0; i < 3; i++) begin
        sq7_r[i] <= m6_r[i] * m6_r[i];
      end
      m7_r     <= m6_r;
      n7_r     <= n6_r;
      deg7_r   <= deg6_r;
      inner7_r <= inner6;
      sum8_r   <= tig_pkg::SUM_W'(sq7_r[0]) + tig_pkg::SUM_W'(sq7_r[1])
                + tig_pkg::SUM_W'(sq7_r[2]);
      m8_r     <= m7_r;
      n8_r     <= n7_r;
      deg8_r   <= deg7_r;
      inner8_r <= inner7_r;
    end
  end

  // square root with the rest of the item alongside
  tig_pkg::tig_ctl_t      sq_ctl;
  logic [SIDE_W-1:0]      side_in, side_out;
  logic                   vq;
  logic [tig_pkg::ROOT_W-1:0] root;

  always_comb begin
    side_in = '0;
    for (int i = 0; i < 9; i++) begin
      side_in[i*C +: C] = inner8_r[i];
    end
    side_in[IN_W]         = deg8_r;
    side_in[IN_W+1 +: 3]  = n8_r;
    for (int i = 0; i < 3; i++) begin
      side_in[DSIDE_W + i*MAG_W +: MAG_W] = m8_r[i];
    end
  end

  assign sq_ctl.en  = en;
  assign sq_ctl.vld = v8_r;

  tig_isqrt #(
    .SIDE_W(SIDE_W)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sq_ctl),
    .x     (sum8_r),
    .side_i(side_in),
    .vld_o (vq),
    .root  (root),
    .side_o(side_out)
  );

  // divider lanes
  logic [QB-1:0] quot [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    tig_div_lane u_div (
      .clk (clk),
      .en  (en),
      .mag (side_out[DSIDE_W + i*MAG_W +: MAG_W]),
      .len (root),
      .quot(quot[i])
    );
  end

  logic [DLY-1:0]     dl_v_r;
  logic [DSIDE_W-1:0] dl_side_r [DLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_v_r <= '0;
    end else if (en) begin
      dl_v_r <= {dl_v_r[DLY-2:0], vq};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_side_r[0] <= side_out[DSIDE_W-1:0];
      for (int i = 1; i < DLY; i++) begin
        dl_side_r[i] <= dl_side_r[i-1];
      end
    end
  end

  // merge lanes into one result
  logic [DSIDE_W-1:0]     fin;
  logic                   fin_v;
  logic signed [C-1:0]    fin_in [9];
  logic signed [NW-1:0]   fin_nrm [3];
  logic [QB-1:0]          qc;

  assign fin   = dl_side_r[DLY-1];
  assign fin_v = dl_v_r[DLY-1];

  always_comb begin
    qc = '0;
    for (int i = 0; i < 9; i++) begin
      fin_in[i] = $signed(fin[i*C +: C]);
    end
    for (int i = 0; i < 3; i++) begin
      qc         = (quot[i] > QONE) ? QONE : quot[i];
      fin_nrm[i] = fin[IN_W+1+i] ? -$signed(NW'(qc)) : $signed(NW'(qc));
    end
    if (fin[IN_W]) begin
      fin_nrm[0] = '0;
      fin_nrm[1] = NW'(tig_pkg::NORM_ONE);
      fin_nrm[2] = '0;
    end
  end

  // output register and skid
  logic                 out_valid_r, skid_full_r;
  logic signed [C-1:0]  oin_r [9], skin_r [9];
  logic signed [NW-1:0] onrm_r [3], sknrm_r [3];
  logic                 out_take, push;

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;
  assign out_take = out_valid_r && !out_stall;
  assign push     = en && fin_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_take) begin
        skid_full_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_take) begin
        skid_full_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_take) begin
        oin_r  <= skin_r;
        onrm_r <= sknrm_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_take) begin
        skin_r  <= fin_in;
        sknrm_r <= fin_nrm;
      end else begin
        oin_r  <= fin_in;
        onrm_r <= fin_nrm;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_inner_a_x = oin_r[0];
  assign out_inner_a_y = oin_r[1];
  assign out_inner_a_z = oin_r[2];
  assign out_inner_b_x = oin_r[3];
  assign out_inner_b_y = oin_r[4];
  assign out_inner_b_z = oin_r[5];
  assign out_inner_c_x = oin_r[6];
  assign out_inner_c_y = oin_r[7];
  assign out_inner_c_z = oin_r[8];
  assign out_normal_x  = onrm_r[0];
  assign out_normal_y  = onrm_r[1];
  assign out_normal_z  = onrm_r[2];

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_normal_x <= tig_pkg::NORM_ONE && out_normal_x >= -tig_pkg::NORM_ONE
      && out_normal_y <= tig_pkg::NORM_ONE && out_normal_y >= -tig_pkg::NORM_ONE
      && out_normal_z <= tig_pkg::NORM_ONE && out_normal_z >= -tig_pkg::NORM_ONE))
    else $error("normal component out of range");

endmodule
